/* rtl/core/rtb_pkg.sv */
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared constants and types for the raster timing register block.
// ----------------------------------------------------------------------------
package rtb_pkg;

  localparam int REGISTER_COUNT = 47;
  localparam int ADDR_W         = 6;
  localparam int RF_AW          = $clog2(REGISTER_COUNT);

  // item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // configuration register indexes
  localparam logic CFG_CYCLES = 1'b0;
  localparam logic CFG_LINES  = 1'b1;

  localparam logic [7:0] CYCLES_RESET = 8'd63;
  localparam logic [8:0] LINES_RESET  = 9'd312;

  // special register addresses
  localparam logic [ADDR_W-1:0] REG_CONTROL    = 6'h11;
  localparam logic [ADDR_W-1:0] REG_RASTER     = 6'h12;
  localparam logic [ADDR_W-1:0] REG_SPRITE_HIT = 6'h1E;
  localparam logic [ADDR_W-1:0] REG_BG_HIT     = 6'h1F;

  localparam logic [8:0] BAD_FIRST   = 9'h030;
  localparam logic [8:0] BAD_LAST    = 9'h0F7;
  localparam logic [7:0] STALL_FIRST = 8'd15;
  localparam logic [7:0] STALL_LAST  = 8'd54;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic [7:0]        sprite_bits;
    logic [7:0]        bg_bits;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic       ba;
    logic       aec;
    logic       badline;
    logic [8:0] line;
    logic [7:0] cycle;
  } status_t;

  function automatic logic addr_in_range(input logic [ADDR_W-1:0] a);
    return {1'b0, a} < (ADDR_W + 1)'(REGISTER_COUNT);
  endfunction

endpackage

/* rtl/core/raster_timing_register_block.sv */
// ----------------------------------------------------------------------------
// raster_timing_register_block
// Raster line/cycle timing with badline BA/AEC generation and a video
// register file with collision latches.
//
//   channel  | handshake            | contents
//   ---------+----------------------+---------------------------------------
//   in       | in_valid / in_ready  | mode, reg_address, write_data, hit bits
//   out      | out_valid / out_ready| read_data, BA, AEC, badline, line, cycle
//   config   | cfg_we               | cfg_index, cfg_data
//
// One beat per clock sustained while the output is not stalled; an accepted
// beat passes through the input register, which also waits on the register
// file RAM read, then the result register. Output stall backs up through
// in_ready combinationally. Reset clears valid bits and control state only.
// ----------------------------------------------------------------------------
module raster_timing_register_block (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [5:0]  reg_address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  sprite_hit_bits,
  input  logic [7:0]  background_hit_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        bus_available,
  output logic        address_enable,
  output logic        badline_flag,
  output logic [8:0]  current_line,
  output logic [7:0]  current_cycle
);

  logic [7:0]       line_length;
  logic [8:0]       lines_per_frame;
  logic             s1_valid;
  rtb_pkg::cmd_t    s1_cmd;
  logic             out_free;
  logic             adv;
  logic             in_fire;
  rtb_pkg::wr_t     wr;
  logic [7:0]       stored;
  logic [2:0]       ctrl;
  logic [7:0]       rd_next;
  rtb_pkg::status_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= rtb_pkg::CYCLES_RESET;
      lines_per_frame <= rtb_pkg::LINES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rtb_pkg::CFG_CYCLES: line_length     <= cfg_data[7:0];
        rtb_pkg::CFG_LINES:  lines_per_frame <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  assign adv      = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd.mode        <= mode;
      s1_cmd.addr        <= reg_address;
      s1_cmd.wdata       <= write_data;
      s1_cmd.sprite_bits <= sprite_hit_bits;
      s1_cmd.bg_bits     <= background_hit_bits;
    end
  end

  always_comb begin
    wr.en   = adv && (s1_cmd.mode == rtb_pkg::MODE_WRITE) &&
              rtb_pkg::addr_in_range(s1_cmd.addr);
    wr.addr = s1_cmd.addr[rtb_pkg::RF_AW-1:0];
    wr.data = s1_cmd.wdata;
  end

  rtb_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (in_fire),
    .rd_addr(reg_address),
    .wr     (wr),
    .stored (stored),
    .ctrl   (ctrl)
  );

  rtb_timing u_timing (
    .clk            (clk),
    .rst            (rst),
    .go             (adv),
    .cmd            (s1_cmd),
    .stored         (stored),
    .ctrl           (ctrl),
    .line_length    (line_length),
    .lines_per_frame(lines_per_frame),
    .rd_next        (rd_next),
    .st_next        (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_data      <= rd_next;
      bus_available  <= st_next.ba;
      address_enable <= st_next.aec;
      badline_flag   <= st_next.badline;
      current_line   <= st_next.line;
      current_cycle  <= st_next.cycle;
    end
  end

endmodule

/* rtl/core/rtb_ram.sv */
// ----------------------------------------------------------------------------
// rtb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 47
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/rtb_regfile.sv */
// ----------------------------------------------------------------------------
// rtb_regfile
// Video register file: RAM with per-entry valid bits, write forwarding and a
// shadow copy of control register bits [2:0] for the badline compare.
// ----------------------------------------------------------------------------
module rtb_regfile (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [rtb_pkg::ADDR_W-1:0] rd_addr,
  input  rtb_pkg::wr_t               wr,
  output logic [7:0]                 stored,
  output logic [2:0]                 ctrl
);

  logic [rtb_pkg::RF_AW-1:0]  raddr;
  logic [7:0]                 ram_q;
  logic [rtb_pkg::REGISTER_COUNT-1:0] valid;
  logic                       vld_q;
  logic                       fwd_hit;
  logic [7:0]                 fwd_data;

  assign raddr = rd_addr[rtb_pkg::RF_AW-1:0];

  rtb_ram #(
    .WIDTH(8),
    .DEPTH(rtb_pkg::REGISTER_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ctrl  <= '0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
        if ({{(rtb_pkg::ADDR_W - rtb_pkg::RF_AW){1'b0}}, wr.addr} == rtb_pkg::REG_CONTROL) begin
          ctrl <= wr.data[2:0];
        end
      end
    end
  end

  // the RAM returns pre-write data when the beat ahead writes the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_q    <= valid[raddr];
      fwd_hit  <= wr.en && (wr.addr == raddr);
      fwd_data <= wr.data;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      stored = fwd_data;
    end else if (vld_q) begin
      stored = ram_q;
    end else begin
      stored = 8'd0;
    end
  end

endmodule

/* rtl/core/rtb_timing.sv */
// ----------------------------------------------------------------------------
// rtb_timing
// Raster counters, badline detect, BA/AEC levels, collision latches and the
// read data select for one beat.
// ----------------------------------------------------------------------------
module rtb_timing (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  rtb_pkg::cmd_t   cmd,
  input  logic [7:0]      stored,
  input  logic [2:0]      ctrl,
  input  logic [7:0]      line_length,
  input  logic [8:0]      lines_per_frame,
  output logic [7:0]      rd_next,
  output rtb_pkg::status_t st_next
);

  logic [7:0] cycle, cycle_next;
  logic [8:0] line, line_next;
  logic [7:0] spr, spr_next;
  logic [7:0] bgl, bgl_next;
  logic       bad, bad_next;
  logic       prev_ba, prev_ba_next;
  logic       ba, ba_next;
  logic       aec, aec_next;

  logic [8:0] cyc_inc;
  logic [9:0] line_inc;
  logic [7:0] t_cycle;
  logic [8:0] t_line;
  logic       t_bad;
  logic       t_ba;
  logic       in_range;

  always_comb begin
    cyc_inc  = {1'b0, cycle} + 9'd1;
    line_inc = {1'b0, line} + 10'd1;
    if (cyc_inc >= {1'b0, line_length}) begin
      t_cycle = 8'd0;
      t_line  = (line_inc >= {1'b0, lines_per_frame}) ? 9'd0 : line_inc[8:0];
    end else begin
      t_cycle = cyc_inc[7:0];
      t_line  = line;
    end
    t_bad = (t_line >= rtb_pkg::BAD_FIRST) && (t_line <= rtb_pkg::BAD_LAST) &&
            (t_line[2:0] == ctrl);
    t_ba  = !(t_bad && (t_cycle >= rtb_pkg::STALL_FIRST) &&
              (t_cycle <= rtb_pkg::STALL_LAST));
  end

  always_comb begin
    cycle_next   = cycle;
    line_next    = line;
    spr_next     = spr;
    bgl_next     = bgl;
    bad_next     = bad;
    prev_ba_next = prev_ba;
    ba_next      = ba;
    aec_next     = aec;
    rd_next      = 8'd0;
    in_range     = rtb_pkg::addr_in_range(cmd.addr);

    if (go) begin
      case (cmd.mode)
        rtb_pkg::MODE_TICK: begin
          cycle_next = t_cycle;
          line_next  = t_line;
          bad_next   = t_bad;
          ba_next    = t_ba;
          // AEC falls when BA falls, rises when BA rises, and holds otherwise
          if (prev_ba && !t_ba) begin
            aec_next = 1'b0;
          end else if (!prev_ba && t_ba) begin
            aec_next = 1'b1;
          end
          prev_ba_next = t_ba;
          spr_next     = spr | cmd.sprite_bits;
          bgl_next     = bgl | cmd.bg_bits;
        end
        rtb_pkg::MODE_READ: begin
          if (in_range) begin
            if (cmd.addr == rtb_pkg::REG_RASTER) begin
              rd_next = line[7:0];
            end else if (cmd.addr == rtb_pkg::REG_SPRITE_HIT) begin
              rd_next  = spr;
              spr_next = 8'd0;
            end else if (cmd.addr == rtb_pkg::REG_BG_HIT) begin
              rd_next  = bgl;
              bgl_next = 8'd0;
            end else begin
              rd_next = stored;
            end
          end
        end
        default: begin
        end
      endcase
    end

    st_next.ba      = ba_next;
    st_next.aec     = aec_next;
    st_next.badline = bad_next;
    st_next.line    = line_next;
    st_next.cycle   = cycle_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle   <= 8'd0;
      line    <= 9'd0;
      spr     <= 8'd0;
      bgl     <= 8'd0;
      bad     <= 1'b0;
      prev_ba <= 1'b0;
      ba      <= 1'b1;
      aec     <= 1'b1;
    end else begin
      cycle   <= cycle_next;
      line    <= line_next;
      spr     <= spr_next;
      bgl     <= bgl_next;
      bad     <= bad_next;
      prev_ba <= prev_ba_next;
      ba      <= ba_next;
      aec     <= aec_next;
    end
  end

endmodule
